>>> rtl/cstrip_pkg.sv
// Package for the C comment stripper: character codes, scan mode encoding
// and the queue entry type shared by the front end, queue and back end.
// No dependencies.
`timescale 1ns / 1ps

package cstrip_pkg;

    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_DQUOTE  = 8'd34;
    localparam logic [7:0] CH_SQUOTE  = 8'd39;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    typedef enum logic [6:0] {
        MODE_OUTSIDE = 7'b0000001,
        MODE_SLASH   = 7'b0000010,
        MODE_BLOCK   = 7'b0000100,
        MODE_STAR    = 7'b0001000,
        MODE_LINE    = 7'b0010000,
        MODE_DSTR    = 7'b0100000,
        MODE_SSTR    = 7'b1000000
    } mode_t;

    // One or two output bytes caused by a single input byte
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } slot_t;

    // Mode after a non-slash byte is handled outside any comment
    function automatic mode_t quote_mode(input logic [7:0] c);
        mode_t m;
        m = MODE_OUTSIDE;
        if (c == CH_DQUOTE)
        begin
            m = MODE_DSTR;
        end
        else if (c == CH_SQUOTE)
        begin
            m = MODE_SSTR;
        end
        return m;
    endfunction

endpackage

>>> rtl/cstrip_front.sv
// Front end of the comment stripper: accepts source bytes, runs the scan
// mode machine and pushes the resulting output bytes into the queue.
// Depends on cstrip_pkg.
`timescale 1ns / 1ps

module cstrip_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  logic [7:0]          ch,
    input  logic                end_of_text,
    input  logic                q_full,
    output cstrip_pkg::slot_t   push
);
    import cstrip_pkg::*;

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [1:0] n_out;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       accept;

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    always_comb
    begin
        mode_next = mode_reg;
        n_out     = 2'd0;
        b0        = ch;
        b1        = ch;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (ch == CH_STAR)
                begin
                    n_out     = 2'd1;
                    b0        = CH_SPACE;
                    mode_next = MODE_BLOCK;
                end
                else if (ch == CH_SLASH)
                begin
                    mode_next = MODE_LINE;
                end
                else
                begin
                    // lone slash: emit it, then treat the byte as outside
                    n_out     = 2'd2;
                    b0        = CH_SLASH;
                    mode_next = quote_mode(ch);
                end
            end
            MODE_BLOCK:
            begin
                if (ch == CH_NEWLINE)
                begin
                    n_out = 2'd1;
                end
                else if (ch == CH_STAR)
                begin
                    mode_next = MODE_STAR;
                end
            end
            MODE_STAR:
            begin
                if (ch == CH_SLASH)
                begin
                    mode_next = MODE_OUTSIDE;
                end
                else if (ch != CH_STAR)
                begin
                    if (ch == CH_NEWLINE)
                    begin
                        n_out = 2'd1;
                    end
                    mode_next = MODE_BLOCK;
                end
            end
            MODE_LINE:
            begin
                if (ch == CH_NEWLINE)
                begin
                    n_out     = 2'd2;
                    b0        = CH_SPACE;
                    mode_next = MODE_OUTSIDE;
                end
            end
            MODE_DSTR:
            begin
                n_out = 2'd1;
                if (ch == CH_DQUOTE)
                begin
                    mode_next = MODE_OUTSIDE;
                end
            end
            MODE_SSTR:
            begin
                n_out = 2'd1;
                if (ch == CH_SQUOTE)
                begin
                    mode_next = MODE_OUTSIDE;
                end
            end
            default:
            begin
                if (ch == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else
                begin
                    n_out     = 2'd1;
                    mode_next = quote_mode(ch);
                end
            end
        endcase

        // end of text: flush a pending slash and drop back to outside
        if (end_of_text)
        begin
            if (mode_next == MODE_SLASH)
            begin
                n_out = 2'd1;
                b0    = CH_SLASH;
            end
            mode_next = MODE_OUTSIDE;
        end
    end

    assign push.valid     = accept && (n_out != 2'd0);
    assign push.entry.two = (n_out == 2'd2);
    assign push.entry.b0  = b0;
    assign push.entry.b1  = b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OUTSIDE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

>>> rtl/cstrip_queue.sv
// Small circular queue of output entries between the front and back ends.
// Depends on cstrip_pkg.
`timescale 1ns / 1ps

module cstrip_queue #(
    parameter int Depth = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cstrip_pkg::slot_t   push,
    output logic                full,
    output cstrip_pkg::slot_t   head,
    input  logic                pop
);
    import cstrip_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    entry_t            mem [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        r = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
        return r;
    endfunction

    assign full       = (count_reg == CntW'(Depth));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("queue count exceeds depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !pop) |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("push without pop did not grow the queue");
`endif

endmodule

>>> rtl/cstrip_back.sv
// Back end of the comment stripper: takes queue entries and delivers their
// one or two bytes through the output register, marking the last with run_end.
// Depends on cstrip_pkg.
`timescale 1ns / 1ps

module cstrip_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cstrip_pkg::slot_t   head,
    output logic                pop,
    output logic                dst_valid,
    input  logic                dst_stall,
    output logic [7:0]          out_byte,
    output logic                run_end
);
    import cstrip_pkg::*;

    logic   cur_valid_reg;
    logic   sel_reg;
    entry_t cur_entry_reg;
    logic   out_acc;

    assign dst_valid = cur_valid_reg;
    assign out_byte  = sel_reg ? cur_entry_reg.b1 : cur_entry_reg.b0;
    assign run_end   = sel_reg || !cur_entry_reg.two;
    assign out_acc   = cur_valid_reg && !dst_stall;

    // load the next entry when the register is empty or its last byte leaves
    assign pop = head.valid && (!cur_valid_reg || (out_acc && run_end));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            sel_reg       <= 1'b0;
        end
        else if (out_acc)
        begin
            if (run_end)
            begin
                cur_valid_reg <= 1'b0;
                sel_reg       <= 1'b0;
            end
            else
            begin
                sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_entry_reg <= head.entry;
        end
    end

`ifndef SYNTHESIS
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !run_end) |=> dst_valid && run_end && sel_reg)
        else $error("second byte of a pair did not follow");

    a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && sel_reg) |-> cur_entry_reg.two)
        else $error("second slot selected for a single-byte entry");

    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> cur_valid_reg && !sel_reg)
        else $error("loaded entry not presented");
`endif

endmodule

>>> rtl/c_comment_stripper.sv
// C comment stripper top level. Order: the queue is written at the edge that
// accepts a byte, the output register then loads from the queue head, and
// the first result leaves from the output register. Throughput: one source
// byte per cycle in while the queue is not full, one result byte per cycle
// out while dst_stall is low; a byte that causes two results holds the output
// for two transactions, and the queue of Depth entries absorbs the difference.
// Reset: scan mode outside, queue and output register empty.
`timescale 1ns / 1ps

module c_comment_stripper #(
    parameter int Depth = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] ch,
    input  logic       end_of_text,
    output logic       dst_valid,
    input  logic       dst_stall,
    output logic [7:0] out_byte,
    output logic       run_end
);
    import cstrip_pkg::*;

    slot_t push;
    slot_t head;
    logic  q_full;
    logic  pop;

    cstrip_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .ch          (ch),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push)
    );

    cstrip_queue #(
        .Depth (Depth)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    cstrip_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .out_byte  (out_byte),
        .run_end   (run_end)
    );

endmodule
